// ----- rtl/sync_length_checksum_deframer_macros.svh -----
// Assertion macros for the checker module of the sync/length/checksum deframer.
// Depends on nothing; the using module must have aclk and aresetn in scope.
`ifndef SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SLCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/slcd_pkg.sv -----
// Package for the sync/length/checksum deframer: widths, constants and the result type.
// Depends on nothing; used by every module of the block.
package slcd_pkg;

    localparam int BYTE_W               = 8;
    localparam int INDEX_W              = 10;
    localparam int LEN_W                = 16;
    localparam int DEFAULT_BUFFER_BYTES = 1024;
    localparam int MIN_FRAME_LEN        = 4;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;

    typedef struct packed {
        logic               store_valid;
        logic [BYTE_W-1:0]  store_byte;
        logic [INDEX_W-1:0] store_index;
        logic               frame_end;
        logic               frame_good;
        logic [INDEX_W-1:0] frame_length;
    } slcd_result_t;

endpackage

// ----- rtl/slcd_in_reg.sv -----
// Input register stage of the deframer: holds one received word until the parser takes it.
// Depends on slcd_pkg.
module slcd_in_reg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [slcd_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                       pop,
    output logic                       vld,
    output logic [slcd_pkg::BYTE_W-1:0] data
);
    import slcd_pkg::*;

    logic              vld_reg;
    logic [BYTE_W-1:0] data_reg;

    // The stage refills in the same cycle that its word moves on.
    assign s_ready = !vld_reg || pop;
    assign vld     = vld_reg;
    assign data    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_rx_byte;
        end
    end

endmodule

// ----- rtl/slcd_parser.sv -----
// Frame parser of the deframer: phase, length, index and checksum state plus the result logic.
// Depends on slcd_pkg.
module slcd_parser #(
    parameter int BUFFER_BYTES = slcd_pkg::DEFAULT_BUFFER_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [slcd_pkg::BYTE_W-1:0] rx_byte,
    output slcd_pkg::slcd_result_t      result
);
    import slcd_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_BYTES);
    localparam int EXT_W = IDX_W + INDEX_W;

    localparam logic [2:0] PH_SYNC1   = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_CONTENT = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [BYTE_W-1:0] len_lo_reg, len_lo_next;
    logic [IDX_W-1:0]  frame_len_reg, frame_len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    logic              do_store;
    logic [BYTE_W-1:0] sum_base;
    logic [BYTE_W-1:0] sum_after;
    logic [IDX_W-1:0]  idx_plus1;
    logic [IDX_W-1:0]  len_m1;
    logic [LEN_W-1:0]  len_full;
    logic [EXT_W-1:0]  idx_ext;
    logic [EXT_W-1:0]  len_ext;
    slcd_result_t      res;

    assign idx_plus1 = idx_reg + IDX_W'(1);
    assign len_m1    = frame_len_reg - IDX_W'(1);
    assign len_full  = {rx_byte, len_lo_reg};
    assign idx_ext   = EXT_W'(idx_reg);
    assign len_ext   = EXT_W'(frame_len_reg);
    assign sum_after = sum_base + rx_byte;

    always_comb begin
        phase_next     = phase_reg;
        len_lo_next    = len_lo_reg;
        frame_len_next = frame_len_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        sum_base       = sum_reg;
        do_store       = 1'b0;
        res            = '0;

        case (phase_reg)
            PH_SYNC1: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (rx_byte == SYNC_BYTE) begin
                    phase_next = PH_LEN_LO;
                    idx_next   = '0;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_LEN_LO: begin
                len_lo_next = rx_byte;
                sum_base    = '0;
                do_store    = 1'b1;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_len_next = IDX_W'(len_full);
                do_store       = 1'b1;
                if (len_full < LEN_W'(BUFFER_BYTES) && len_full >= LEN_W'(MIN_FRAME_LEN)) begin
                    phase_next = PH_CONTENT;
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CONTENT: begin
                if (idx_reg < len_m1) begin
                    do_store = 1'b1;
                    if (idx_plus1 == len_m1) begin
                        phase_next = PH_CHECK;
                    end
                end else begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_CHECK: begin
                do_store         = 1'b1;
                res.frame_end    = 1'b1;
                res.frame_good   = (sum_after == '0);
                res.frame_length = len_ext[INDEX_W-1:0];
                phase_next       = PH_SYNC1;
            end
            default: begin
                phase_next = PH_SYNC1;
            end
        endcase

        if (do_store) begin
            res.store_valid = 1'b1;
            res.store_byte  = rx_byte;
            res.store_index = idx_ext[INDEX_W-1:0];
            sum_next        = sum_after;
            idx_next        = idx_plus1;
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC1;
            len_lo_reg    <= '0;
            frame_len_reg <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            len_lo_reg    <= len_lo_next;
            frame_len_reg <= frame_len_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

// ----- rtl/slcd_out_reg.sv -----
// Result register stage of the deframer: holds one result word until the sink takes it.
// Depends on slcd_pkg.
module slcd_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  slcd_pkg::slcd_result_t din,
    output logic                   room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slcd_pkg::slcd_result_t dout
);
    import slcd_pkg::*;

    logic         vld_reg;
    slcd_result_t data_reg;

    assign room    = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign dout    = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (room) begin
            vld_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= din;
        end
    end

endmodule

// ----- rtl/sync_length_checksum_deframer.sv -----
// Sync/length/checksum deframer: one received byte in, one result word out per byte.
// An accepted word waits in the input register and moves through the parser into the result
// register on a step, so its result is registered; a stalled result register holds it back.
// Throughput is one byte per cycle while the sink does not stall; the parser state updates once per byte.
// Reset (aresetn low at a rising edge) empties both stages and returns to sync hunting
// with length, index and checksum cleared. Depends on slcd_pkg and the stage modules.
module sync_length_checksum_deframer #(
    parameter int BUFFER_BYTES = slcd_pkg::DEFAULT_BUFFER_BYTES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_store_valid,
    output logic [slcd_pkg::BYTE_W-1:0]  m_store_byte,
    output logic [slcd_pkg::INDEX_W-1:0] m_store_index,
    output logic                         m_frame_end,
    output logic                         m_frame_good,
    output logic [slcd_pkg::INDEX_W-1:0] m_frame_length
);
    import slcd_pkg::*;

    // A word moves from the input register through the parser into the result
    // register whenever the input register is full and the result register is
    // either empty or being drained in this same cycle. Both registers refill in
    // the cycle they empty, so a steady stream flows at one word per cycle while m_ready stays high.
    logic              in_vld;
    logic [BYTE_W-1:0] in_data;
    logic              out_room;
    logic              step;
    slcd_result_t      parse_res;
    slcd_result_t      out_res;

    assign step = in_vld && out_room;

    slcd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .pop       (step),
        .vld       (in_vld),
        .data      (in_data)
    );

    // The parser advances its phase, length, index and running sum only on a
    // step, so stalls on the result side never disturb the frame state.
    slcd_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_data),
        .result  (parse_res)
    );

    slcd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .din     (parse_res),
        .room    (out_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dout    (out_res)
    );

    // Every accepted byte yields exactly one result word. Fields not in use
    // for a given byte are driven to zero by the parser.
    assign m_store_valid  = out_res.store_valid;
    assign m_store_byte   = out_res.store_byte;
    assign m_store_index  = out_res.store_index;
    assign m_frame_end    = out_res.frame_end;
    assign m_frame_good   = out_res.frame_good;
    assign m_frame_length = out_res.frame_length;

endmodule

// ----- rtl/slcd_checker.sv -----
// Port-level checker for the deframer and the bind that attaches it to the top level.
// Depends on slcd_pkg and sync_length_checksum_deframer_macros.svh.
`include "sync_length_checksum_deframer_macros.svh"

module slcd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [slcd_pkg::BYTE_W-1:0]  s_rx_byte,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_store_valid,
    input logic [slcd_pkg::BYTE_W-1:0]  m_store_byte,
    input logic [slcd_pkg::INDEX_W-1:0] m_store_index,
    input logic                         m_frame_end,
    input logic                         m_frame_good,
    input logic [slcd_pkg::INDEX_W-1:0] m_frame_length
);
    import slcd_pkg::*;

    // The checksum byte is always stored, and it sits at the last position.
    `SLCD_ASSERT_NOW(a_end_stores, m_valid && m_frame_end, m_store_valid && m_frame_length == INDEX_W'(m_store_index + INDEX_W'(1)), "frame end without matching store")

    // A good verdict only exists at frame end.
    `SLCD_ASSERT_NOW(a_good_at_end, m_valid && m_frame_good, m_frame_end, "good flag outside frame end")

    // Bytes outside a frame carry zeroed store fields.
    `SLCD_ASSERT_NOW(a_idle_zero, m_valid && !m_store_valid, m_store_byte == '0 && m_store_index == '0 && !m_frame_end, "stray store fields")

    // A stalled result word holds.
    `SLCD_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_store_byte) && $stable(m_store_index), "result changed while stalled")

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for sync_length_checksum_deframer: random stalls on both channels,
// a built-in frame parser predictor and a word-by-word comparison. Needs slcd_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import slcd_pkg::*;

    localparam int BUF_BYTES      = DEFAULT_BUFFER_BYTES;
    localparam int STIM_TARGET    = 1930;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    // Parser phases as the block walks through a frame.
    typedef enum logic [2:0] {
        HUNT_SYNC1,
        HUNT_SYNC2,
        LEN_LO,
        LEN_HI,
        CONTENT,
        CHECKSUM
    } parse_phase_t;

    // One pending input word. A set hold flag makes the driver wait until every
    // expected result has been received before offering this word.
    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                hold;
    } rx_word_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte      = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_store_valid;
    logic [BYTE_W-1:0]    m_store_byte;
    logic [INDEX_W-1:0]   m_store_index;
    logic                 m_frame_end;
    logic                 m_frame_good;
    logic [INDEX_W-1:0]   m_frame_length;

    rx_word_t     rx_words[$];
    slcd_result_t expected_results[$];
    int unsigned  error_count = 0;
    int unsigned  idle_cycles = 0;

    // Predictor state, at its reset values. Reset is applied only once, at the start.
    parse_phase_t       parse_state = HUNT_SYNC1;
    logic [LEN_W-1:0]   frame_len_seen = '0;
    logic [LEN_W-1:0]   next_pos = '0;
    logic [BYTE_W-1:0]  byte_sum = '0;

    // Random pacing state of the sender and of the receiver.
    int unsigned src_gap   = 0;
    int unsigned sink_stall = 0;
    bit          src_calm  = 1'b0;
    bit          sink_calm = 1'b0;

    sync_length_checksum_deframer #(
        .BUFFER_BYTES(BUF_BYTES)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_store_valid (m_store_valid),
        .m_store_byte  (m_store_byte),
        .m_store_index (m_store_index),
        .m_frame_end   (m_frame_end),
        .m_frame_good  (m_frame_good),
        .m_frame_length(m_frame_length)
    );

    always #6 aclk = ~aclk;

    // Hands a frame byte to the buffer at the next position and folds it into the sum.
    function automatic slcd_result_t stash_byte(input logic [BYTE_W-1:0] rx);
        slcd_result_t r;
        r             = '0;
        r.store_valid = 1'b1;
        r.store_byte  = rx;
        r.store_index = next_pos[INDEX_W-1:0];
        byte_sum      = byte_sum + rx;
        next_pos      = next_pos + 1'b1;
        return r;
    endfunction

    // Advances the frame parser by one received byte and returns the result word it causes.
    function automatic slcd_result_t deframe_byte(input logic [BYTE_W-1:0] rx);
        slcd_result_t r;
        r = '0;
        case (parse_state)
            HUNT_SYNC1: begin
                if (rx == SYNC_BYTE) parse_state = HUNT_SYNC2;
            end
            HUNT_SYNC2: begin
                if (rx == SYNC_BYTE) begin
                    parse_state = LEN_LO;
                    next_pos    = '0;
                end else begin
                    parse_state = HUNT_SYNC1;
                end
            end
            LEN_LO: begin
                frame_len_seen = {8'h00, rx};
                byte_sum       = '0;
                r              = stash_byte(rx);
                parse_state    = LEN_HI;
            end
            LEN_HI: begin
                frame_len_seen = frame_len_seen + {rx, 8'h00};
                r              = stash_byte(rx);
                // A length that leaves no room for content, or that would overflow
                // the buffer, drops the frame once both length bytes are stored.
                if (frame_len_seen < BUF_BYTES && frame_len_seen >= MIN_FRAME_LEN)
                    parse_state = CONTENT;
                else
                    parse_state = HUNT_SYNC1;
            end
            CONTENT: begin
                // The overrun guard should never trip for a well-formed length.
                if (frame_len_seen >= 1 && next_pos < frame_len_seen - 1'b1) begin
                    r = stash_byte(rx);
                    if (next_pos == frame_len_seen - 1'b1) parse_state = CHECKSUM;
                end else begin
                    parse_state = HUNT_SYNC1;
                end
            end
            CHECKSUM: begin
                r              = stash_byte(rx);
                r.frame_end    = 1'b1;
                r.frame_good   = (byte_sum == '0);
                r.frame_length = frame_len_seen[INDEX_W-1:0];
                parse_state    = HUNT_SYNC1;
            end
            default: parse_state = HUNT_SYNC1;
        endcase
        return r;
    endfunction

    // Gap lengths are mostly short, now and then long; in a calm stretch there are none.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] data, input bit hold = 1'b0);
        rx_word_t w;
        w.data = data;
        w.hold = hold;
        rx_words.push_back(w);
    endtask

    // Sync pair followed by a little-endian length; used for lengths that get rejected.
    task automatic push_length_only(input logic [BYTE_W-1:0] len_lo, input logic [BYTE_W-1:0] len_hi);
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(len_lo);
        push_byte(len_hi);
    endtask

    // A complete frame of the given length. With good set the checksum byte brings
    // the sum to zero; otherwise it is off by a random nonzero amount.
    task automatic push_frame(input logic [LEN_W-1:0] len, input bit good);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] content;
        logic [BYTE_W-1:0] check;
        push_byte(SYNC_BYTE);
        push_byte(SYNC_BYTE);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        sum = len[7:0] + len[15:8];
        repeat (len - 3) begin
            content = ($urandom_range(0, 15) == 0) ? SYNC_BYTE : 8'($urandom);
            sum     = sum + content;
            push_byte(content);
        end
        check = -sum;
        if (!good) check = check ^ 8'($urandom_range(1, 255));
        push_byte(check);
    endtask

    task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // Driver: offers the next pending word, holding it until it is accepted.
    // Every accepted word is run through the predictor right away.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(deframe_byte(s_rx_byte));
                if ($urandom_range(0, 149) == 0) src_calm = !src_calm;
                src_gap = pick_gap(src_calm);
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (rx_words.size() > 0 &&
                             !(rx_words[0].hold && expected_results.size() != 0)) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rx_words[0].data;
                    void'(rx_words.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and every accepted result word is checked
    // field by field against the oldest expectation.
    always @(posedge aclk) begin : monitor
        slcd_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t ns: result word with nothing expected, actual store %0b/0x%0h/%0d end %0b",
                         $time, m_store_valid, m_store_byte, m_store_index, m_frame_end);
            end else begin
                want = expected_results.pop_front();
                compare_field("store_valid", want.store_valid, m_store_valid);
                compare_field("store_byte", want.store_byte, m_store_byte);
                compare_field("store_index", want.store_index, m_store_index);
                compare_field("frame_end", want.frame_end, m_frame_end);
                compare_field("frame_good", want.frame_good, m_frame_good);
                compare_field("frame_length", want.frame_length, m_frame_length);
            end
            if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
            sink_stall = pick_gap(sink_calm);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : main
        int unsigned       roll;
        logic [LEN_W-1:0]  len;
        bit                big_done;
        bit                hold_done;
        big_done  = 1'b0;
        hold_done = 1'b0;

        // Directed words: noise while hunting, a broken sync pair, the shortest frame
        // with good and with bad checksum, and lengths rejected as too small or too large.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_BYTE);
        push_byte(8'h55);
        push_frame(16'd4, 1'b1);
        push_frame(16'd4, 1'b0);
        push_length_only(8'h03, 8'h00);
        push_length_only(8'h00, 8'h00);
        push_length_only(8'h00, 8'h04);
        push_length_only(8'hFF, 8'hFF);

        // Random part: mostly well-formed frames of small size with random content,
        // plus rejected lengths, noise and broken sync pairs. One frame of the largest
        // accepted length fills the buffer up to index 1022, and once the sender waits for
        // every outstanding result before going on.
        while (rx_words.size() < STIM_TARGET) begin
            if (!big_done && rx_words.size() > 600) begin
                push_frame(16'(BUF_BYTES - 1), 1'b1);
                big_done = 1'b1;
            end
            if (!hold_done && rx_words.size() > 1200) begin
                push_byte(8'($urandom), 1'b1);
                hold_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(41, 200))
                                                   : 16'($urandom_range(4, 40));
                push_frame(len, $urandom_range(0, 9) < 6);
            end else if (roll < 78) begin
                push_length_only(8'($urandom_range(0, 3)), 8'h00);
            end else if (roll < 85) begin
                push_length_only(8'($urandom), 8'($urandom_range(4, 255)));
            end else if (roll < 95) begin
                repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
            end else begin
                push_byte(SYNC_BYTE);
                push_byte(8'($urandom_range(0, 8'hA9)));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Run until every word is sent and every result has been checked.
        while (!(rx_words.size() == 0 && !s_valid && expected_results.size() == 0) &&
               idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);

        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            // A few more cycles so that a stray extra result word would still be caught.
            repeat (TAIL_CYCLES) @(posedge aclk);
            if (error_count == 0 && expected_results.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ----- sync_length_checksum_deframer.f -----
+incdir+rtl
rtl/slcd_pkg.sv
rtl/slcd_in_reg.sv
rtl/slcd_parser.sv
rtl/slcd_out_reg.sv
rtl/sync_length_checksum_deframer.sv
rtl/slcd_checker.sv
tb/sv/testbench.sv
